// File: rtl/core/ubsp_pkg.sv
`timescale 1ns / 1ps
package ubsp_pkg;

  // coordinate and field widths fixed by the word layout
  localparam int CRD_W   = 32;
  localparam int PARAM_W = 20;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int DEG_W   = 2;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 64;

  // blend quotient after the fraction shift, wide enough for a degree-three sum
  localparam int QW = CRD_W + 5;

  // floor divide by three through a reciprocal, valid for values below 2^20
  localparam int            D3_W   = 20;
  localparam logic [19:0]   D3_M   = 20'hAAAAB;
  localparam int            D3_SH  = 21;
  localparam int            D3_LO  = 17;
  localparam int            D3_UW  = 35;
  localparam int            D3_OFS = 33;

  localparam int ROUNDS = 3;
  localparam int SLOTS  = 4;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_POINT_COUNT  = 1'b0,
    REG_CURVE_DEGREE = 1'b1
  } reg_idx_t;

endpackage

// File: rtl/core/uniform_bspline_point_eval.sv
`timescale 1ns / 1ps
// uniform cubic (or lower degree) b-spline point evaluator, integer knots
// input channel s_*: one word per item; s_tuser is the command
//   write: stores point_x/point_y into slot point_index (no result word)
//   eval : evaluates the curve at param_t and returns one result word
// output channel m_*: curve_x/curve_y in m_tdata, out_of_range in m_tuser
// config channel cfg_*: index 0 point_count, index 1 curve_degree; always ready
// the point store is four copies of one ram so all four de boor points of an
// item are read in the acceptance cycle; every write updates all copies
// throughput: one item per cycle unless m_tready stalls a full pipeline; thirteen pipeline stages,
//   each de boor round being multiply, sum and round, then two divide steps
// a write followed by an eval in the next cycle already sees the new point
// reset clears the pipeline valids and loads point_count 15, degree 3; the
//   point store is not cleared and an unwritten slot reads as garbage
// when m_tready is low the pipeline fills its empty stages and keeps taking
//   items until every stage holds a word, then drops s_tready
module uniform_bspline_point_eval #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ubsp_pkg::IN_W-1:0]           s_tdata,   // point_index, point_x, point_y, param_t
  input  logic                                s_tuser,   // command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ubsp_pkg::OUT_W-1:0]          m_tdata,   // curve_x, curve_y
  output logic                                m_tuser,   // out_of_range
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  ubsp_pkg::reg_idx_t                  cfg_index,
  input  logic [ubsp_pkg::CNT_W-1:0]          cfg_data
);
  import ubsp_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int KW  = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int CW  = (F + KW > PARAM_W) ? F + KW : PARAM_W;
  localparam int FW  = F + 1;
  localparam int WW  = F + 3;
  localparam int PW  = WW + CRD_W + 1;
  localparam int NS  = 1 + 4 * ROUNDS;

  // config registers
  logic [CNT_W-1:0] point_count;
  logic [DEG_W-1:0] curve_degree;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= CNT_W'(15);
      curve_degree <= DEG_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POINT_COUNT:  point_count  <= cfg_data;
        REG_CURVE_DEGREE: curve_degree <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // input word fields
  logic [IDX_W-1:0]   in_idx;
  logic [CRD_W-1:0]   in_x;
  logic [CRD_W-1:0]   in_y;
  logic [PARAM_W-1:0] in_t;

  assign in_idx = s_tdata[IDX_W-1:0];
  assign in_x   = s_tdata[IDX_W +: CRD_W];
  assign in_y   = s_tdata[IDX_W+CRD_W +: CRD_W];
  assign in_t   = s_tdata[IDX_W+2*CRD_W +: PARAM_W];

  // pipeline control: a stage moves when empty or when the next one moves
  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  logic          acc;
  logic          acc_eval;
  logic          acc_wr;

  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign acc      = s_tvalid && s_tready;
  assign acc_eval = acc && (cmd_t'(s_tuser) == CMD_EVAL);
  assign acc_wr   = acc && (cmd_t'(s_tuser) == CMD_WRITE) &&
                    (KW'(in_idx) < KW'(MAX_POINTS));

  // effective degree and count, parameter clamp and interval
  logic [DEG_W-1:0] deg_eff;
  logic [KW-1:0]    pc_lim;
  logic [KW-1:0]    pc_eff;
  logic [KW-1:0]    pc_m1;
  logic [CW-1:0]    t_lo;
  logic [CW-1:0]    t_hi;
  logic [CW-1:0]    t_cl;
  logic             clamp;
  logic [KW-1:0]    i_full;
  logic             at_end;
  logic [KW-1:0]    i_seg;
  logic [FW-1:0]    frac;

  always_comb begin
    deg_eff = (curve_degree == '0) ? DEG_W'(1) : curve_degree;
    pc_lim  = (KW'(point_count) > KW'(MAX_POINTS)) ? KW'(MAX_POINTS) : KW'(point_count);
    pc_eff  = (pc_lim < KW'(deg_eff) + KW'(1)) ? KW'(deg_eff) + KW'(1) : pc_lim;
    pc_m1   = pc_eff - KW'(1);
    t_lo    = CW'(deg_eff) << F;
    t_hi    = CW'(pc_eff) << F;
    clamp   = 1'b0;
    t_cl    = CW'(in_t);
    if (t_cl < t_lo) begin
      t_cl  = t_lo;
      clamp = 1'b1;
    end else if (t_cl >= t_hi) begin
      t_cl  = t_hi;
      clamp = 1'b1;
    end
    i_full  = KW'(t_cl >> F);
    at_end  = i_full > pc_m1;
    i_seg   = at_end ? pc_m1 : i_full;
    // the curve end lands on the last interval with a full fraction
    frac    = at_end ? (FW'(1) << F) : {1'b0, t_cl[F-1:0]};
  end

  // point store: slot s of an item holds point i - 3 + s
  logic [OUT_W-1:0] rd [0:SLOTS-1];

  for (genvar s = 0; s < SLOTS; s++) begin : g_bank
    logic [KW-1:0] sum_a;
    logic [AW-1:0] raddr;

    assign sum_a = i_seg + KW'(s);
    assign raddr = (sum_a < KW'(3)) ? '0 : AW'(sum_a - KW'(3));

    ubsp_ram #(
      .WIDTH (OUT_W),
      .DEPTH (MAX_POINTS)
    ) u_ram (
      .clk   (clk),
      .we    (acc_wr),
      .waddr (AW'(in_idx)),
      .wdata ({in_y, in_x}),
      .re    (en[0]),
      .raddr (raddr),
      .rdata (rd[s])
    );
  end

  // per-stage item data that rides beside the points
  logic [FW-1:0]    sfrac [0:NS-1];
  logic             sflag [0:NS-1];
  logic [DEG_W-1:0] sdeg  [0:NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= acc_eval;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sfrac[0] <= frac;
      sflag[0] <= clamp;
      sdeg[0]  <= deg_eff;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        sfrac[k] <= sfrac[k-1];
        sflag[k] <= sflag[k-1];
        sdeg[k]  <= sdeg[k-1];
      end
    end
  end

  // round outputs; round h blends slots h..3 with divisor 4 - h
  crd_t bnd [1:ROUNDS][0:SLOTS-1][0:1];

  for (genvar gr = 0; gr < ROUNDS; gr++) begin : g_round
    localparam int H  = gr + 1;
    localparam int DV = ROUNDS - gr;
    localparam int SM = 1 + 4 * gr;

    crd_t rin [0:SLOTS-1][0:1];
    crd_t mpt [0:SLOTS-1][0:1];
    crd_t spt [0:SLOTS-1][0:1];
    crd_t dpt [0:SLOTS-1][0:1];
    logic act;

    for (genvar s = 0; s < SLOTS; s++) begin : g_in
      for (genvar c = 0; c < 2; c++) begin : g_crd
        if (gr == 0) begin : g_ram
          assign rin[s][c] = $signed(rd[s][CRD_W*c +: CRD_W]);
        end else begin : g_prev
          assign rin[s][c] = bnd[gr][s][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      for (int s = 0; s < SLOTS; s++) begin
        for (int c = 0; c < 2; c++) begin
          if (en[SM])   mpt[s][c] <= rin[s][c];
          if (en[SM+1]) spt[s][c] <= mpt[s][c];
          if (en[SM+2]) dpt[s][c] <= spt[s][c];
        end
      end
    end

    // rounds whose divisor exceeds the chosen degree pass their points through
    assign act = sdeg[SM+2] >= DEG_W'(DV);

    for (genvar s = 0; s < H; s++) begin : g_keep
      for (genvar c = 0; c < 2; c++) begin : g_crd
        always_ff @(posedge clk) begin
          if (en[SM+3]) begin
            bnd[H][s][c] <= dpt[s][c];
          end
        end
      end
    end

    for (genvar s = H; s < SLOTS; s++) begin : g_blend
      localparam logic [WW-1:0] WA_OFS = WW'(SLOTS - 1 - s) << F;
      localparam logic [WW-1:0] WB_BAS = WW'(s - H + 1) << F;

      logic [WW-1:0] wa;
      logic [WW-1:0] wb;

      assign wa = WW'(sfrac[SM-1]) + WA_OFS;
      assign wb = WB_BAS - WW'(sfrac[SM-1]);

      for (genvar c = 0; c < 2; c++) begin : g_crd
        logic signed [PW-1:0] mpa;
        logic signed [PW-1:0] mpb;
        logic signed [PW:0]   sumv;
        logic signed [PW:0]   shv;
        logic signed [QW-1:0] sq;

        // weighted points
        always_ff @(posedge clk) begin
          if (en[SM]) begin
            mpa <= $signed({1'b0, wa}) * rin[s][c];
            mpb <= $signed({1'b0, wb}) * rin[s-1][c];
          end
        end

        // sum, round half up, drop the fraction
        assign sumv = {mpa[PW-1], mpa} + {mpb[PW-1], mpb} +
                      ((PW + 1)'(DV) << (F - 1));
        assign shv  = sumv >>> F;

        always_ff @(posedge clk) begin
          if (en[SM+1]) begin
            sq <= shv[QW-1:0];
          end
        end

        if (DV == 3) begin : g_div3
          // floor(q / 3): offset to positive, then two short reciprocal steps
          logic [QW-1:0]          u;
          logic [D3_UW-D3_LO-1:0] ua;
          logic [2*D3_W-3:0]      pa;
          logic [D3_UW-D3_LO-2:0] qa_c;
          logic [D3_UW-D3_LO-1:0] ra_w;
          logic [D3_UW-D3_LO-2:0] qa;
          logic [1:0]             ra;
          logic [D3_LO-1:0]       ub;
          logic [D3_LO+1:0]       xb;
          logic [2*D3_W-2:0]      pb;
          logic [D3_UW-1:0]       res;

          assign u    = sq + (QW'(3) << D3_OFS);
          assign ua   = u[D3_UW-1:D3_LO];
          assign pa   = ua * D3_M;
          assign qa_c = pa[D3_SH +: D3_UW-D3_LO-1];
          assign ra_w = ua - {qa_c, 1'b0} - {1'b0, qa_c};

          always_ff @(posedge clk) begin
            if (en[SM+2]) begin
              qa <= qa_c;
              ra <= ra_w[1:0];
              ub <= u[D3_LO-1:0];
            end
          end

          assign xb  = {ra, ub};
          assign pb  = xb * D3_M;
          assign res = {qa, {D3_LO{1'b0}}} + D3_UW'(pb[2*D3_W-2:D3_SH]) -
                       (D3_UW'(1) << D3_OFS);

          always_ff @(posedge clk) begin
            if (en[SM+3]) begin
              bnd[H][s][c] <= act ? $signed(res[CRD_W-1:0]) : dpt[s][c];
            end
          end
        end else begin : g_div2
          logic signed [QW-1:0] dq;

          always_ff @(posedge clk) begin
            if (en[SM+2]) begin
              dq <= sq >>> (DV - 1);
            end
          end

          always_ff @(posedge clk) begin
            if (en[SM+3]) begin
              bnd[H][s][c] <= act ? dq[CRD_W-1:0] : dpt[s][c];
            end
          end
        end
      end
    end
  end

  assign m_tvalid = vld[NS-1];
  assign m_tdata  = {bnd[ROUNDS][SLOTS-1][1], bnd[ROUNDS][SLOTS-1][0]};
  assign m_tuser  = sflag[NS-1];

`ifndef NO_ASSERTIONS
  a_ready_full : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld))
    else $error("input stalled while a stage is empty");

  a_count_ok : assert property (@(posedge clk) disable iff (rst)
    (pc_eff > KW'(deg_eff)) && (pc_eff <= KW'(MAX_POINTS)) && (deg_eff != '0))
    else $error("effective count or degree out of range");

  a_seg_ok : assert property (@(posedge clk) disable iff (rst)
    acc_eval |-> (i_seg >= KW'(deg_eff)) && (i_seg <= pc_m1) &&
                 (frac <= (FW'(1) << F)))
    else $error("interval or fraction out of range");

  a_stage0 : assert property (@(posedge clk) disable iff (rst)
    acc |=> (vld[0] == $past(acc_eval)))
    else $error("stage zero valid does not follow the command");
`endif

endmodule

// File: rtl/core/ubsp_ram.sv
`timescale 1ns / 1ps
module ubsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: verif/uniform_bspline_point_eval_chk.sv
`timescale 1ns / 1ps
// watches the item, result and register channels, predicts each curve point
module uniform_bspline_point_eval_chk (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [ubsp_pkg::IN_W-1:0]  s_tdata,
  input  logic                       s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [ubsp_pkg::OUT_W-1:0] m_tdata,
  input  logic                       m_tuser,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  ubsp_pkg::reg_idx_t         cfg_index,
  input  logic [ubsp_pkg::CNT_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);
  import ubsp_pkg::*;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic        oor;
  } curve_pt_t;

  localparam int FB = 16;

  curve_pt_t   curve_q[$];
  logic [63:0] pts [16];
  logic [4:0]  npts;
  logic [1:0]  deg_reg;

  function automatic longint rdiv(longint num, longint den);
    longint n;
    n = num + den / 2;
    if (n >= 0) return n / den;
    return -((-n + den - 1) / den);
  endfunction

  function automatic curve_pt_t eval_point(logic [19:0] tin);
    curve_pt_t   res;
    longint      vx [4];
    longint      vy [4];
    int          dg, pc, iv, d;
    longint      t, j, wa, wb;
    logic [63:0] e;
    dg = (deg_reg == 2'd0) ? 1 : int'(deg_reg);
    pc = (npts > 5'd16) ? 16 : int'(npts);
    if (pc < dg + 1) pc = dg + 1;
    t = longint'(tin);
    res.oor = 1'b0;
    if (t < (longint'(dg) << FB)) begin
      t = longint'(dg) << FB;
      res.oor = 1'b1;
    end else if (t >= (longint'(pc) << FB)) begin
      t = longint'(pc) << FB;
      res.oor = 1'b1;
    end
    iv = int'(t >> FB);
    if (iv > pc - 1) iv = pc - 1;
    for (int k = 0; k <= dg; k++) begin
      e = pts[(iv - dg + k) % 16];
      vx[k] = longint'($signed(e[31:0]));
      vy[k] = longint'($signed(e[63:32]));
    end
    for (int r = 1; r <= dg; r++) begin
      d = dg - r + 1;
      for (int k = dg; k >= r; k--) begin
        j = longint'(iv - dg + k);
        wa = t - (j << FB);
        wb = ((j + longint'(d)) << FB) - t;
        vx[k] = rdiv(wa * vx[k] + wb * vx[k-1], longint'(d) << FB);
        vy[k] = rdiv(wa * vy[k] + wb * vy[k-1], longint'(d) << FB);
      end
    end
    res.cx = vx[dg][31:0];
    res.cy = vy[dg][31:0];
    return res;
  endfunction

  assign pending = curve_q.size();

  always @(posedge clk) begin
    curve_pt_t want;
    int        errs;
    errs = 0;
    if (rst) begin
      npts <= 5'd15;
      deg_reg <= 2'd3;
      fail_count <= 0;
      checked <= 0;
      curve_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POINT_COUNT) npts <= cfg_data;
        else deg_reg <= cfg_data[1:0];
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_WRITE)
          pts[s_tdata[3:0]] = {s_tdata[67:36], s_tdata[35:4]};
        else
          curve_q.insert(curve_q.size(), eval_point(s_tdata[87:68]));
      end
      if (m_tvalid && m_tready) begin
        checked <= checked + 1;
        if (curve_q.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          want = curve_q.pop_front();
          if (m_tdata[31:0] !== want.cx) begin
            $error("curve_x exp %h got %h", want.cx, m_tdata[31:0]);
            errs++;
          end
          if (m_tdata[63:32] !== want.cy) begin
            $error("curve_y exp %h got %h", want.cy, m_tdata[63:32]);
            errs++;
          end
          if (m_tuser !== want.oor) begin
            $error("out_of_range exp %b got %b", want.oor, m_tuser);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// File: verif/uniform_bspline_point_eval_tb.sv
`timescale 1ns / 1ps
module uniform_bspline_point_eval_tb;
  import ubsp_pkg::*;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  reg_idx_t            cfg_index;
  logic [CNT_W-1:0]    cfg_data;
  int                  fail_count;
  int                  pending;
  int                  checked;
  int                  cycle_cnt;
  int                  evals_sent;
  bit                  hold_off;   // long receiver stall request

  uniform_bspline_point_eval uut (.*);

  uniform_bspline_point_eval_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit with wide margin: a run that hangs reports fail
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall pattern, long hold-off when requested
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else if (cycle_cnt % 512 < 128) m_tready <= 1'b1;   // no-stall stretch
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // one word on the item channel, held until taken
  task automatic send_word(cmd_t cmd, logic [3:0] idx, logic [31:0] px,
                           logic [31:0] py, logic [19:0] t);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {t, py, px, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_EVAL) evals_sent++;
  endtask

  task automatic idle_gap(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic put_point(logic [3:0] idx, logic [31:0] px, logic [31:0] py);
    send_word(CMD_WRITE, idx, px, py, 20'($urandom));
  endtask

  task automatic eval_at(logic [19:0] t);
    send_word(CMD_EVAL, 4'($urandom), $urandom, $urandom, t);
  endtask

  // registers only change once the pipeline has drained
  task automatic set_reg(reg_idx_t idx, logic [4:0] val);
    idle_gap(0);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // half moderate coordinates, the rest full-scale extremes or fully random
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
    endcase
  endfunction

  // parameters mostly inside range, some in the clamped zones
  function automatic logic [19:0] rand_param();
    case ($urandom_range(0, 7))
      0: return 20'($urandom_range(0, 20'hfffff));
      1: return 20'($urandom_range(0, 20'h3ffff));
      2: return {4'($urandom_range(0, 15)), 16'h0000};
      default: return 20'($urandom_range(20'h10000, 20'hfffff));
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        if ($urandom_range(0, 4) == 0)
          put_point(4'($urandom_range(0, 15)), rand_coord(), rand_coord());
        else
          eval_at(rand_param());
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_WRITE;
    cfg_valid = 1'b0;
    cfg_index = REG_POINT_COUNT;
    cfg_data = '0;
    hold_off = 1'b0;
    cycle_cnt = 0;
    evals_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every slot so no unwritten entry is ever read
    for (int k = 0; k < 16; k++)
      put_point(4'(k), rand_coord(), rand_coord());

    // directed: extremes of coordinates and parameter, clamping at both ends
    put_point(4'd0, 32'h7fffffff, 32'h80000000);
    put_point(4'd15, 32'h80000000, 32'h7fffffff);
    eval_at(20'h00000);
    eval_at(20'h30000);
    eval_at(20'h3ffff);
    eval_at(20'h0ffff);
    eval_at(20'hf0000);
    eval_at(20'hfffff);
    eval_at(20'h7_8000);
    put_point(4'd7, 32'h0, 32'hffffffff);
    eval_at(20'h8_0000);

    // degree 0 acts as 1, tiny count raised to degree + 1
    set_reg(REG_CURVE_DEGREE, 5'd0);
    set_reg(REG_POINT_COUNT, 5'd0);
    eval_at(20'h0_0000);
    eval_at(20'h1_8000);
    eval_at(20'hfffff);

    // long receiver hold-off while items keep coming
    set_reg(REG_POINT_COUNT, 5'd31);
    set_reg(REG_CURVE_DEGREE, 5'd3);
    hold_off = 1'b1;
    fork
      random_phase(60);
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join

    // random phases over several register settings, extremes among them
    set_reg(REG_POINT_COUNT, 5'd16);
    set_reg(REG_CURVE_DEGREE, 5'd1);
    random_phase(300);
    set_reg(REG_POINT_COUNT, 5'd2);
    random_phase(200);
    set_reg(REG_CURVE_DEGREE, 5'd2);
    set_reg(REG_POINT_COUNT, 5'd9);
    random_phase(300);
    set_reg(REG_CURVE_DEGREE, 5'd3);
    set_reg(REG_POINT_COUNT, 5'd4);
    random_phase(300);
    set_reg(REG_POINT_COUNT, 5'd16);
    random_phase(400);

    idle_gap(0);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d evaluations, %0d result words checked, degrees 0..3,",
             evals_sent, checked);
    $display("point counts 0..31, clamping at both ends, long output stall");
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/ubsp_pkg.sv
rtl/core/ubsp_ram.sv
rtl/core/uniform_bspline_point_eval.sv
verif/uniform_bspline_point_eval_chk.sv
verif/uniform_bspline_point_eval_tb.sv
